FILE: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared definitions of the fixed-point ALU
// Widths, command codes, operation classes and the classified word that
// travels from the front end through the queue to the execution back end.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int DATA_W      = 32;
    localparam int INT_W       = 24;
    localparam int CMD_W       = 5;
    localparam int NUM_W       = DATA_W + FRAC_BITS;
    localparam int REM_W       = DATA_W + 1;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SH_W        = 10;
    localparam int POS_W       = $clog2(DATA_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // IEEE single layout
    localparam int FLT_MAN_W   = 23;
    localparam int FLT_EXP_W   = 8;
    localparam int FLT_BIAS    = 127;
    localparam int FLT_SIG_W   = FLT_MAN_W + 1;
    localparam int RND_W       = DATA_W - FLT_SIG_W;

    // Float to fixed shift bounds
    localparam int F2X_EXP_OFS    = 150 - FRAC_BITS;
    localparam int F2X_DENORM_SH  = FRAC_BITS - 149;
    localparam int F2X_MAX_SHIFT  = 40;
    localparam int F2X_DROP_SHIFT = 26;
    localparam int F2X_LSH_W      = 6;
    localparam int F2X_RSH_W      = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 5'd0,
        CMD_SUB = 5'd1,
        CMD_MUL = 5'd2,
        CMD_DIV = 5'd3,
        CMD_EQ  = 5'd4,
        CMD_NE  = 5'd5,
        CMD_LT  = 5'd6,
        CMD_LE  = 5'd7,
        CMD_GT  = 5'd8,
        CMD_GE  = 5'd9,
        CMD_MIN = 5'd10,
        CMD_MAX = 5'd11,
        CMD_INC = 5'd12,
        CMD_DEC = 5'd13,
        CMD_I2X = 5'd14,
        CMD_F2X = 5'd15,
        CMD_X2I = 5'd16,
        CMD_X2F = 5'd17
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_SIMPLE = 3'd0,
        KIND_MUL    = 3'd1,
        KIND_DIV    = 3'd2,
        KIND_F2X    = 3'd3,
        KIND_X2F    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [DATA_W-1:0]         raw;
        logic [INT_W-1:0]          ires;
        logic                      cond;
        logic                      dz;
        logic                      neg;
        logic [DATA_W-1:0]         opa;
        logic [DATA_W-1:0]         opb;
        logic signed [SH_W-1:0]    fsh;
        logic [FLT_SIG_W-1:0]      fman;
        logic                      fsat;
    } item_t;

endpackage

FILE: rtl/fpa_if.sv
// ----------------------------------------------------------------------------
// fpa_req_if / fpa_rsp_if: request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fpa_req_if;
    import fpa_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
    logic signed [INT_W-1:0]  int_in;
    logic [DATA_W-1:0]        float_in;

    modport source (output valid, cmd, operand_a, operand_b, int_in, float_in,
                    input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, int_in, float_in,
                    output ready);
endinterface

interface fpa_rsp_if;
    import fpa_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] raw_result;
    logic signed [INT_W-1:0]  int_result;
    logic [DATA_W-1:0]        float_result;
    logic                     cond_true;
    logic                     div_by_zero;

    modport source (output valid, raw_result, int_result, float_result,
                    cond_true, div_by_zero, input ready);
    modport sink   (input valid, raw_result, int_result, float_result,
                    cond_true, div_by_zero, output ready);
endinterface

FILE: rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: command decode and classification
// Registers each request word, works out the simple-command results and
// prepares operands for the multiplier, divider and float converters.
// ----------------------------------------------------------------------------
module fpa_front (
    input  logic           clk,
    input  logic           rst_n,
    fpa_req_if.sink        req,
    output logic           item_valid,
    input  logic           item_ready,
    output fpa_pkg::item_t item
);
    import fpa_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    item_t                    item_reg;
    item_t                    item_next;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [DATA_W-1:0]        sum;
    logic [DATA_W-1:0]        diff;
    logic                     lt;
    logic                     eq;
    logic [FLT_EXP_W-1:0]     fexp;

    assign req.ready  = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        a    = req.operand_a;
        b    = req.operand_b;
        sum  = a + b;
        diff = a - b;
        lt   = a < b;
        eq   = a == b;
        fexp = req.float_in[DATA_W-2 -: FLT_EXP_W];

        item_next      = '0;
        item_next.kind = KIND_SIMPLE;
        unique case (req.cmd)
            CMD_ADD: item_next.raw = sum;
            CMD_SUB: item_next.raw = diff;
            CMD_MUL:
            begin
                item_next.kind = KIND_MUL;
                item_next.opa  = a;
                item_next.opb  = b;
            end
            CMD_DIV:
            begin
                item_next.kind = KIND_DIV;
                item_next.dz   = (b == '0);
                item_next.neg  = a[DATA_W-1] ^ b[DATA_W-1];
                item_next.opa  = a[DATA_W-1] ? -a : a;
                item_next.opb  = b[DATA_W-1] ? -b : b;
            end
            CMD_EQ:  item_next.cond = eq;
            CMD_NE:  item_next.cond = !eq;
            CMD_LT:  item_next.cond = lt;
            CMD_LE:  item_next.cond = lt || eq;
            CMD_GT:  item_next.cond = !(lt || eq);
            CMD_GE:  item_next.cond = !lt;
            CMD_MIN: item_next.raw  = (lt || eq) ? a : b;
            CMD_MAX: item_next.raw  = (!lt) ? a : b;
            CMD_INC: item_next.raw  = a + DATA_W'(1);
            CMD_DEC: item_next.raw  = a - DATA_W'(1);
            CMD_I2X:
            begin
                item_next.raw = {{(DATA_W-INT_W){req.int_in[INT_W-1]}}, req.int_in}
                                << FRAC_BITS;
            end
            CMD_F2X:
            begin
                item_next.kind = KIND_F2X;
                item_next.neg  = req.float_in[DATA_W-1];
                item_next.fsat = &fexp;
                if (fexp == '0)
                begin
                    item_next.fman = {1'b0, req.float_in[FLT_MAN_W-1:0]};
                    item_next.fsh  = SH_W'(F2X_DENORM_SH);
                end
                else
                begin
                    item_next.fman = {1'b1, req.float_in[FLT_MAN_W-1:0]};
                    item_next.fsh  = $signed({{(SH_W-FLT_EXP_W){1'b0}}, fexp})
                                     - SH_W'(F2X_EXP_OFS);
                end
            end
            CMD_X2I: item_next.ires = INT_W'(a >>> FRAC_BITS);
            CMD_X2F:
            begin
                item_next.kind = KIND_X2F;
                item_next.neg  = a[DATA_W-1];
                item_next.opa  = a[DATA_W-1] ? -a : a;
            end
            default: item_next = '0;
        endcase

        valid_next = valid_reg && !item_ready;
        if (req.valid && req.ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// fpa_queue: short queue between front end and back end
// A small register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module fpa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  fpa_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output fpa_pkg::item_t pop_item
);
    import fpa_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: execution pipeline
// Multiplier, float-to-fixed shifter, a restoring divider with one quotient
// bit per stage and a leading-one normaliser with one shift per stage.
// ----------------------------------------------------------------------------
module fpa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  fpa_pkg::item_t item,
    fpa_rsp_if.source      rsp
);
    import fpa_pkg::*;

    typedef struct packed {
        kind_t                    kind;
        logic [DATA_W-1:0]        raw;
        logic [INT_W-1:0]         ires;
        logic                     cond;
        logic                     dz;
        logic                     neg;
        logic signed [PROD_W-1:0] prod;
        logic [DATA_W-1:0]        fmag;
        logic                     fbig;
        logic [NUM_W-1:0]         dvd;
        logic [DATA_W-1:0]        dvs;
        logic [REM_W-1:0]         rem;
        logic [NUM_W-1:0]         quo;
        logic [DATA_W-1:0]        nrm;
        logic [POS_W-1:0]         pos;
    } stage_t;

    function automatic stage_t step(stage_t s);
        stage_t           r;
        logic [REM_W-1:0] trial;
        r     = s;
        trial = {s.rem[REM_W-2:0], s.dvd[NUM_W-1]};
        r.dvd = {s.dvd[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, s.dvs})
        begin
            r.rem = trial - {1'b0, s.dvs};
            r.quo = {s.quo[NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial;
            r.quo = {s.quo[NUM_W-2:0], 1'b0};
        end
        if (s.nrm != '0 && !s.nrm[DATA_W-1])
        begin
            r.nrm = s.nrm << 1;
            r.pos = s.pos - 1'b1;
        end
        return r;
    endfunction

    stage_t                 stg_reg [NUM_W+1];
    logic                   vld_reg [NUM_W+1];
    stage_t                 first_next;
    logic                   advance;
    logic                   out_valid_reg;
    logic [DATA_W-1:0]      raw_reg;
    logic [DATA_W-1:0]      raw_next;
    logic [INT_W-1:0]       ires_reg;
    logic [DATA_W-1:0]      fres_reg;
    logic [DATA_W-1:0]      fres_next;
    logic                   cond_reg;
    logic                   dz_reg;
    logic [PROD_W-1:0]      wide;
    logic [SH_W-1:0]        nsh;
    logic [FLT_SIG_W:0]     rnd;
    stage_t                 last;
    logic [NUM_W-1:0]       qsigned;
    logic [FLT_SIG_W-1:0]   keep;
    logic [RND_W-1:0]       rbits;
    logic                   up;
    logic [FLT_SIG_W:0]     kp;
    logic [FLT_EXP_W-1:0]   fexp;
    logic [FLT_MAN_W-1:0]   fman;

    assign advance    = !out_valid_reg || rsp.ready;
    assign item_ready = advance;

    // First stage: multiplier, float shifter, divider and normaliser set-up
    always_comb
    begin
        first_next      = '0;
        first_next.kind = item.kind;
        first_next.raw  = item.raw;
        first_next.ires = item.ires;
        first_next.cond = item.cond;
        first_next.dz   = item.dz;
        first_next.neg  = item.neg;
        first_next.prod = $signed(item.opa) * $signed(item.opb);
        first_next.dvd  = {item.opa, {FRAC_BITS{1'b0}}};
        first_next.dvs  = item.opb;
        first_next.nrm  = item.opa;
        first_next.pos  = POS_W'(DATA_W - 1);

        wide = '0;
        nsh  = '0;
        rnd  = '0;
        if (item.fsat || (!item.fsh[SH_W-1] && item.fsh > SH_W'(F2X_MAX_SHIFT)))
        begin
            first_next.fbig = 1'b1;
        end
        else if (!item.fsh[SH_W-1])
        begin
            wide = {{(PROD_W-FLT_SIG_W){1'b0}}, item.fman}
                   << item.fsh[F2X_LSH_W-1:0];
            first_next.fbig = |wide[PROD_W-1:DATA_W-1];
            first_next.fmag = wide[DATA_W-1:0];
        end
        else
        begin
            nsh = -item.fsh;
            if (nsh < SH_W'(F2X_DROP_SHIFT))
            begin
                rnd = ({1'b0, item.fman}
                       + ((FLT_SIG_W+1)'(1) << (nsh[F2X_RSH_W-1:0] - 1'b1)))
                      >> nsh[F2X_RSH_W-1:0];
                first_next.fmag = DATA_W'(rnd);
            end
        end
    end

    // Last stage: finish each class of operation
    always_comb
    begin
        last    = stg_reg[NUM_W];
        qsigned = last.neg ? -last.quo : last.quo;
        keep    = last.nrm[DATA_W-1 -: FLT_SIG_W];
        rbits   = last.nrm[RND_W-1:0];
        up      = (rbits > {1'b1, {(RND_W-1){1'b0}}})
                  || (rbits == {1'b1, {(RND_W-1){1'b0}}} && keep[0]);
        kp      = {1'b0, keep} + (FLT_SIG_W+1)'(up);
        fexp    = FLT_EXP_W'(last.pos) + FLT_EXP_W'(FLT_BIAS - FRAC_BITS)
                  + FLT_EXP_W'(kp[FLT_SIG_W]);
        fman    = kp[FLT_SIG_W] ? '0 : kp[FLT_MAN_W-1:0];

        raw_next  = last.raw;
        fres_next = '0;
        case (last.kind)
            KIND_MUL: raw_next = last.prod[FRAC_BITS +: DATA_W];
            KIND_DIV: raw_next = last.dz ? '0 : qsigned[DATA_W-1:0];
            KIND_F2X:
            begin
                if (last.fbig)
                begin
                    raw_next = last.neg ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
                end
                else
                begin
                    raw_next = last.neg ? -last.fmag : last.fmag;
                end
            end
            KIND_X2F:
            begin
                raw_next  = '0;
                fres_next = (last.nrm == '0) ? '0 : {last.neg, fexp, fman};
            end
            default: raw_next = last.raw;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NUM_W; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i <= NUM_W; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stg_reg[0] <= first_next;
            for (int i = 1; i <= NUM_W; i++)
            begin
                stg_reg[i] <= step(stg_reg[i-1]);
            end
            raw_reg  <= raw_next;
            ires_reg <= last.ires;
            fres_reg <= fres_next;
            cond_reg <= last.cond;
            dz_reg   <= last.dz && (last.kind == KIND_DIV);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.raw_result   = raw_reg;
    assign rsp.int_result   = ires_reg;
    assign rsp.float_result = fres_reg;
    assign rsp.cond_true    = cond_reg;
    assign rsp.div_by_zero  = dz_reg;

endmodule

FILE: rtl/fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_unit: signed Q24.8 fixed-point ALU
// Front end, word queue and pipelined back end of the fixed-point ALU.
// ----------------------------------------------------------------------------
// The unit takes one request word per clock cycle while it holds ready high and
// returns exactly one response word for each, in order. Every word, whatever
// the command, passes a registered decode stage, a four-entry queue and an
// execution pipeline of FRAC_BITS + 33 stages (41 with eight fraction bits),
// then an output register. The pipeline length is set by the divider, which
// resolves one quotient bit per stage over all 40 bits of the shifted
// dividend; the float normaliser shares those stages. While a response word
// waits and the response side holds ready low the pipeline freezes, and the
// queue and the decode register absorb up to five further words before the
// request side sees ready fall.
module fixed_point_alu_unit (
    input  logic      clk,
    input  logic      rst_n,
    fpa_req_if.sink   req,
    fpa_rsp_if.source rsp
);
    import fpa_pkg::*;

    // Classified words from the front end into the queue
    logic  front_valid;
    logic  front_ready;
    item_t front_item;

    // Words from the queue into the execution pipeline
    logic  back_valid;
    logic  back_ready;
    item_t back_item;

    // Decode and simple-command results
    fpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    // Decoupling queue
    fpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    // Multiply, divide and conversion pipeline
    fpa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .rsp        (rsp)
    );

endmodule
